[rtl/etf_pkg.sv]
// ----------------------------------------------------------------------------
// etf_pkg
// Shared widths, constants and small arithmetic helpers for the escape-time
// fractal pixel block.
// ----------------------------------------------------------------------------
package etf_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int ITERATION_CAP = 512;
  localparam int FRACTION_BITS = 16;
  localparam int MIN_ITER      = 16;
  localparam int BIG_SHIFT     = 30;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int SPAN_W     = 25;
  localparam int POINT_W    = 19;
  localparam int ITER_W     = 10;
  localparam int PIX_W      = 32;
  localparam int COV_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 38;
  localparam int DIFF_W = DIM_W + 1;
  localparam int OFF_W  = DVD_W + 1;
  localparam int Z_W    = 48;
  localparam int C_W    = OFF_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAL  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIMAG  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAL    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd7;

  localparam logic [1:0] PAL_RAINBOW = 2'd0;
  localparam logic [1:0] PAL_FIRE    = 2'd1;
  localparam logic [1:0] PAL_OCEAN   = 2'd2;
  localparam logic [1:0] PAL_GRAY    = 2'd3;

  localparam int HUE_SECTOR = 171;
  localparam int SAT        = 220;
  localparam int RECIP_171  = 383;
  localparam logic [7:0] RAINBOW_P = 8'(255 * (255 - SAT) / 255);

  localparam logic signed [Z_W-1:0] Z_BIG  = Z_W'(64'd1 << BIG_SHIFT);
  localparam logic signed [Z_W-1:0] Z_NBIG = -Z_BIG;
  localparam logic signed [Z_W-1:0] ESC_LIMIT = Z_W'(64'd4 << FRACTION_BITS);

  localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

  typedef struct packed {
    logic             in_set;
    logic [1:0]       palette;
    logic [ITER_W-1:0] hue;
  } col_req_t;

  // exact x/255 for x below 65281
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // x/171 by reciprocal with one correction step, x up to 43605
  function automatic logic [7:0] div171(input logic [15:0] x);
    logic [24:0] m;
    logic [7:0]  q;
    logic [16:0] r;
    m = 25'(x) * 25'(RECIP_171);
    q = m[23:16];
    r = 17'(x) - 17'(q) * 17'(HUE_SECTOR);
    if (r >= 17'(HUE_SECTOR)) q = q + 8'd1;
    return q;
  endfunction

  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] o,
                                             input logic [PIX_W-1:0] n,
                                             input logic [COV_W-1:0] cov);
    logic [PIX_W-1:0] res;
    logic [7:0]       ic;
    ic = 8'd255 - cov;
    for (int i = 0; i < 4; i++) begin
      res[i*8 +: 8] = div255(16'(o[i*8 +: 8]) * 16'(ic) + 16'(n[i*8 +: 8]) * 16'(cov));
    end
    return res;
  endfunction

endpackage

[rtl/etf_pixel_if.sv]
// ----------------------------------------------------------------------------
// etf_pixel_if
// Pixel request channel: coordinates, existing pixel and coverage.
// ----------------------------------------------------------------------------
interface etf_pixel_if import etf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [PIX_W-1:0]   old_pixel;
  logic [COV_W-1:0]   coverage;

  modport source (output valid, pixel_x, pixel_y, old_pixel, coverage, input ready);
  modport sink (input valid, pixel_x, pixel_y, old_pixel, coverage, output ready);
endinterface

[rtl/etf_result_if.sv]
// ----------------------------------------------------------------------------
// etf_result_if
// Result channel: blended pixel and iteration count.
// ----------------------------------------------------------------------------
interface etf_result_if import etf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  new_pixel;
  logic [ITER_W-1:0] iteration_count;

  modport source (output valid, new_pixel, iteration_count, input ready);
  modport sink (input valid, new_pixel, iteration_count, output ready);
endinterface

[rtl/etf_cfg_if.sv]
// ----------------------------------------------------------------------------
// etf_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface etf_cfg_if import etf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/etf_mul.sv]
// ----------------------------------------------------------------------------
// etf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module etf_mul import etf_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[rtl/etf_div.sv]
// ----------------------------------------------------------------------------
// etf_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etf_div import etf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DIM_W-1:0] dsr;
  logic [DIM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DIM_W:0]   acc;
  logic             fits;

  assign acc  = {rem, quotient[DVD_W-1]};
  assign fits = acc >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DVD_W);
        dsr      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? DIM_W'(acc - {1'b0, dsr}) : acc[DIM_W-1:0];
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/etf_color.sv]
// ----------------------------------------------------------------------------
// etf_color
// Three-stage palette lookup: hue sector, sector remainder, channel values.
// ----------------------------------------------------------------------------
module etf_color import etf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  col_req_t         req,
  output logic             valid,
  output logic [PIX_W-1:0] colour
);

  logic [2:0] vld;
  col_req_t   req1, req2;
  logic [7:0] region1, region2;
  logic [7:0] hr1;
  logic [7:0] rem2;
  logic [7:0] region_c;
  logic [7:0] sr, tr, q, t, v;
  logic [PIX_W-1:0] col_c;

  assign region_c = div171(16'(req.hue));

  always_comb begin
    sr = div255(16'(rem2) * 16'(SAT));
    tr = div255(16'(8'd255 - rem2) * 16'(SAT));
    q  = 8'd255 - sr;
    t  = 8'd255 - tr;
    v  = req2.hue[7:0];
    col_c = OPAQUE_BLACK;
    if (!req2.in_set) begin
      case (req2.palette)
        PAL_RAINBOW: begin
          case (region2)
            8'd0:    col_c = {8'hFF, 8'hFF, t, RAINBOW_P};
            8'd1:    col_c = {8'hFF, q, 8'hFF, RAINBOW_P};
            8'd2:    col_c = {8'hFF, RAINBOW_P, 8'hFF, t};
            8'd3:    col_c = {8'hFF, RAINBOW_P, q, 8'hFF};
            8'd4:    col_c = {8'hFF, t, RAINBOW_P, 8'hFF};
            default: col_c = {8'hFF, 8'hFF, RAINBOW_P, q};
          endcase
        end
        PAL_FIRE:  col_c = {8'hFF, v, v, 8'd255 - (v >> 1)};
        PAL_OCEAN: col_c = {8'hFF, v >> 1, v, 8'd255 - v};
        default:   col_c = {8'hFF, v, v, v};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
    req1    <= req;
    region1 <= region_c;
    hr1     <= 8'(16'(req.hue) - 16'(region_c) * 16'(HUE_SECTOR));
    req2    <= req1;
    region2 <= region1;
    rem2    <= div171(16'(hr1) * 16'd255);
    colour  <= col_c;
  end

  assign valid = vld[2];

endmodule

[rtl/escape_time_fractal_pixel_top.sv]
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_top
// Escape-time fractal pixel generator (Mandelbrot / Julia), Q16.16.
//
// pixel:  request channel, one pixel coordinate with old ARGB and coverage.
// result: blended ARGB pixel and the iteration count, one per request.
// cfg:    register writes, always ready; write only while the block is idle.
// One pixel is worked on at a time; pixel.ready is high only in idle.
// Each axis mapping takes one multiply and a divide, every iteration
// runs on the shared multiplier (two squares, cross term, update), the
// colour scale of an escaped point takes another divide and the palette
// lookup follows. The worst case is 512 iterations.
// The result sits in an output register; a new pixel may be taken while it
// waits, and the block stalls before writing the next result until the
// previous one has been transferred.
// Reset (synchronous) loads the register defaults and empties the block.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_top import etf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  etf_pixel_if.sink     pixel,
  etf_result_if.source  result,
  etf_cfg_if.sink       cfg
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_MAP_MUL  = 12'b0000_0000_0010,
    S_MAP_DIV  = 12'b0000_0000_0100,
    S_MAP_WAIT = 12'b0000_0000_1000,
    S_IT_RR    = 12'b0000_0001_0000,
    S_IT_II    = 12'b0000_0010_0000,
    S_IT_RI    = 12'b0000_0100_0000,
    S_IT_UPD   = 12'b0000_1000_0000,
    S_COL_DIV  = 12'b0001_0000_0000,
    S_COL_WAIT = 12'b0010_0000_0000,
    S_COL_CALC = 12'b0100_0000_0000,
    S_BLEND    = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic                      mode;
  logic signed [POINT_W-1:0] point_re;
  logic signed [POINT_W-1:0] point_im;
  logic [SPAN_W-1:0]         span;
  logic [ITER_W-1:0]         max_iter;
  logic [1:0]                pal;
  logic [DIM_W-1:0]          width;
  logic [DIM_W-1:0]          height;

  // per-pixel state
  logic [PIX_W-1:0]         old_q;
  logic [COV_W-1:0]         cov_q;
  logic [DIM_W-1:0]         w_eff;
  logic [ITER_W-1:0]        lim;
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic                     axis;
  logic                     neg;
  logic signed [OFF_W-1:0]  off_r;
  logic signed [Z_W-1:0]    zr, zi, zr2, zi2;
  logic signed [C_W-1:0]    cr, ci;
  logic [ITER_W-1:0]        it;
  logic [PIX_W-1:0]         col_q;

  logic [DIM_W-1:0]  w_c, h_c;
  logic [ITER_W-1:0] lim_c;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, prod_mag;

  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DIM_W-1:0] div_dsr;

  logic             col_start, col_valid;
  col_req_t         col_req;
  logic [PIX_W-1:0] colour;

  logic signed [OFF_W-1:0] off_c;
  logic                    at_lim, z_big, escaped, load;

  etf_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(prod));

  etf_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  etf_color u_color (
    .clk, .rst, .start(col_start), .req(col_req), .valid(col_valid), .colour
  );

  // effective limits of the configuration
  always_comb begin
    w_c = width;
    if (width == '0) w_c = DIM_W'(1);
    if (width > DIM_W'(MAX_DIMENSION)) w_c = DIM_W'(MAX_DIMENSION);
    h_c = height;
    if (height > DIM_W'(MAX_DIMENSION)) h_c = DIM_W'(MAX_DIMENSION);
    lim_c = max_iter;
    if (max_iter < ITER_W'(MIN_ITER)) lim_c = ITER_W'(MIN_ITER);
    if (max_iter > ITER_W'(ITERATION_CAP)) lim_c = ITER_W'(ITERATION_CAP);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MAP_MUL: begin
        mul_a = MUL_W'(axis ? diff_y : diff_x);
        mul_b = $signed(MUL_W'(span));
      end
      S_IT_RR: begin
        mul_a = zr[MUL_W-1:0];
        mul_b = zr[MUL_W-1:0];
      end
      S_IT_II: begin
        mul_a = zi[MUL_W-1:0];
        mul_b = zi[MUL_W-1:0];
      end
      S_IT_RI: begin
        mul_a = zr[MUL_W-1:0];
        mul_b = zi[MUL_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign at_lim   = it == lim;
  assign z_big    = zr > Z_BIG || zr < Z_NBIG || zi > Z_BIG || zi < Z_NBIG;
  assign escaped  = (zr2 + zi2) > ESC_LIMIT;
  assign prod_mag = prod[PROD_W-1] ? -prod : prod;
  assign off_c    = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  assign div_start = (state == S_MAP_DIV) || (state == S_COL_DIV && !at_lim);
  always_comb begin
    if (state == S_MAP_DIV) begin
      div_dvd = prod_mag[DVD_W-1:0];
    end else if (pal == PAL_RAINBOW) begin
      div_dvd = DVD_W'({it, 10'b0}) - DVD_W'(it);
    end else begin
      div_dvd = DVD_W'({it, 8'b0}) - DVD_W'(it);
    end
  end
  assign div_dsr = (state == S_MAP_DIV) ? w_eff : DIM_W'(lim);

  assign col_start       = (state == S_COL_DIV && at_lim) || (state == S_COL_WAIT && div_done);
  assign col_req.in_set  = at_lim;
  assign col_req.palette = pal;
  assign col_req.hue     = at_lim ? '0 : div_q[ITER_W-1:0];

  assign pixel.ready = state == S_IDLE;
  assign cfg.ready   = 1'b1;
  assign load        = state == S_BLEND && (!result.valid || result.ready);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      point_re <= POINT_W'(-32768);
      point_im <= '0;
      span     <= SPAN_W'(196608);
      max_iter <= ITER_W'(128);
      pal      <= PAL_RAINBOW;
      width    <= DIM_W'(512);
      height   <= DIM_W'(512);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:   mode     <= cfg.data[0];
        REG_PREAL:  point_re <= cfg.data[POINT_W-1:0];
        REG_PIMAG:  point_im <= cfg.data[POINT_W-1:0];
        REG_SPAN:   span     <= cfg.data[SPAN_W-1:0];
        REG_MAXIT:  max_iter <= cfg.data[ITER_W-1:0];
        REG_PAL:    pal      <= cfg.data[1:0];
        REG_WIDTH:  width    <= cfg.data[DIM_W-1:0];
        REG_HEIGHT: height   <= cfg.data[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            old_q  <= pixel.old_pixel;
            cov_q  <= pixel.coverage;
            w_eff  <= w_c;
            lim    <= lim_c;
            diff_x <= $signed(DIFF_W'(pixel.pixel_x)) - $signed(DIFF_W'(w_c[DIM_W-1:1]));
            diff_y <= $signed(DIFF_W'(pixel.pixel_y)) - $signed(DIFF_W'(h_c[DIM_W-1:1]));
            axis   <= 1'b0;
            state  <= S_MAP_MUL;
          end
        end
        S_MAP_MUL: state <= S_MAP_DIV;
        S_MAP_DIV: begin
          neg   <= prod[PROD_W-1];
          state <= S_MAP_WAIT;
        end
        S_MAP_WAIT: begin
          if (div_done) begin
            if (!axis) begin
              off_r <= off_c;
              axis  <= 1'b1;
              state <= S_MAP_MUL;
            end else begin
              if (mode) begin
                zr <= Z_W'(off_r);
                zi <= Z_W'(off_c);
                cr <= C_W'(point_re);
                ci <= C_W'(point_im);
              end else begin
                zr <= '0;
                zi <= '0;
                cr <= C_W'(off_r) + C_W'(point_re);
                ci <= C_W'(off_c) + C_W'(point_im);
              end
              it    <= '0;
              state <= S_IT_RR;
            end
          end
        end
        S_IT_RR: state <= (at_lim || z_big) ? S_COL_DIV : S_IT_II;
        S_IT_II: begin
          zr2   <= Z_W'(prod >>> FRACTION_BITS);
          state <= S_IT_RI;
        end
        S_IT_RI: begin
          zi2   <= Z_W'(prod >>> FRACTION_BITS);
          state <= S_IT_UPD;
        end
        S_IT_UPD: begin
          if (escaped) begin
            state <= S_COL_DIV;
          end else begin
            zr    <= zr2 - zi2 + Z_W'(cr);
            zi    <= Z_W'(prod >>> (FRACTION_BITS - 1)) + Z_W'(ci);
            it    <= it + 1'b1;
            state <= S_IT_RR;
          end
        end
        S_COL_DIV: state <= at_lim ? S_COL_CALC : S_COL_WAIT;
        S_COL_WAIT: begin
          if (div_done) state <= S_COL_CALC;
        end
        S_COL_CALC: begin
          if (col_valid) begin
            col_q <= colour;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (load) begin
            result.new_pixel       <= blend(old_q, col_q, cov_q);
            result.iteration_count <= it;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // iteration count stays within the limit
  a_it_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IT_RR || state == S_IT_UPD) |-> it <= lim)
    else $error("iteration count beyond limit");

  // divider is only started while it is free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // full coverage of a point that never escaped gives opaque black
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    (load && at_lim && cov_q == 8'd255) |=> result.new_pixel == OPAQUE_BLACK)
    else $error("inside point not black");

endmodule
